@@ rtl/kslp_pkg.sv @@
`default_nettype none
package kslp_pkg;

    localparam int unsigned KEY_COUNT_DEF = 2;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] TICK_MAX = '1;

    localparam int unsigned CFG_W = 16;
    localparam logic [CFG_W-1:0] LOCKOUT_RESET    = 16'd100;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_LOCKOUT    = 1'b0,
        REG_LONG_PRESS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] lockout_ms;
        logic [CFG_W-1:0] long_press_ms;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/kslp_cfg_regs.sv @@
`default_nettype none
module kslp_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kslp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [kslp_pkg::DATA_W-1:0]   pwdata,
    output logic      [kslp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output kslp_pkg::cfg_t                     cfg
);

    logic [kslp_pkg::CFG_W-1:0] lockout_reg;
    logic [kslp_pkg::CFG_W-1:0] lockout_next;
    logic [kslp_pkg::CFG_W-1:0] long_press_reg;
    logic [kslp_pkg::CFG_W-1:0] long_press_next;
    logic                       wr_en;
    kslp_pkg::reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = kslp_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        lockout_next    = lockout_reg;
        long_press_next = long_press_reg;
        if (wr_en)
        begin
            case (idx)
                kslp_pkg::REG_LOCKOUT:    lockout_next    = pwdata[kslp_pkg::CFG_W-1:0];
                kslp_pkg::REG_LONG_PRESS: long_press_next = pwdata[kslp_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg    <= kslp_pkg::LOCKOUT_RESET;
            long_press_reg <= kslp_pkg::LONG_PRESS_RESET;
        end
        else
        begin
            lockout_reg    <= lockout_next;
            long_press_reg <= long_press_next;
        end
    end

    always_comb
    begin
        case (idx)
            kslp_pkg::REG_LOCKOUT:
                prdata = {{(kslp_pkg::DATA_W-kslp_pkg::CFG_W){1'b0}}, lockout_reg};
            kslp_pkg::REG_LONG_PRESS:
                prdata = {{(kslp_pkg::DATA_W-kslp_pkg::CFG_W){1'b0}}, long_press_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.lockout_ms    = lockout_reg;
    assign cfg.long_press_ms = long_press_reg;

endmodule
`default_nettype wire

@@ rtl/kslp_key_eval.sv @@
`default_nettype none
module kslp_key_eval #(
    parameter int unsigned KEY_COUNT = kslp_pkg::KEY_COUNT_DEF
) (
    input  wire kslp_pkg::cfg_t             cfg,
    input  wire logic [KEY_COUNT-1:0]       raw,
    input  wire logic [KEY_COUNT-1:0]       held,
    input  wire logic [KEY_COUNT-1:0]       rep,
    input  wire logic [kslp_pkg::CNT_W-1:0] count,
    output logic      [KEY_COUNT-1:0]       held_next,
    output logic      [KEY_COUNT-1:0]       rep_next,
    output logic      [kslp_pkg::CNT_W-1:0] count_next,
    output logic      [KEY_COUNT-1:0]       shorts,
    output logic      [KEY_COUNT-1:0]       longs
);

    logic [kslp_pkg::CNT_W-1:0] tick;
    logic                       past_lock;
    logic                       past_long;
    logic                       lock_zero;

    // saturating advance, then the shared compares
    assign tick      = (count == kslp_pkg::TICK_MAX) ? count : count + 1'b1;
    assign past_lock = tick >= cfg.lockout_ms;
    assign past_long = tick > cfg.long_press_ms;
    assign lock_zero = cfg.lockout_ms == '0;

    // Once a key zeroes the counter, later keys see zero: they act only with
    // no lockout, and can never see a long press.
    always_comb
    begin
        logic reset_seen;
        logic act;
        logic long_ok;
        reset_seen = 1'b0;
        act        = 1'b0;
        long_ok    = 1'b0;
        held_next  = held;
        rep_next   = rep;
        shorts     = '0;
        longs      = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            act     = reset_seen ? lock_zero : past_lock;
            long_ok = !reset_seen && past_long;
            if (act)
            begin
                if (held[k])
                begin
                    if (long_ok && !rep[k])
                    begin
                        longs[k]    = 1'b1;
                        rep_next[k] = 1'b1;
                    end
                    else if (!raw[k])
                    begin
                        held_next[k] = 1'b0;
                        reset_seen   = 1'b1;
                        shorts[k]    = !rep[k];
                        rep_next[k]  = 1'b0;
                    end
                end
                else if (raw[k])
                begin
                    held_next[k] = 1'b1;
                    reset_seen   = 1'b1;
                end
            end
        end
        count_next = reset_seen ? '0 : tick;
    end

endmodule
`default_nettype wire

@@ rtl/key_short_long_press_detector.sv @@
// Short/long key-press detector.
// Input channel (in_valid/in_ready, key_down_raw): one beat per millisecond
// tick, one raw level bit per key. Output channel (out_valid/out_ready,
// short_press, long_press, held_keys): exactly one beat per input beat.
// Config through the APB port: lockout_ms at 0x0, long_press_ms at 0x4;
// write only while no beat is in flight.
// An accepted beat is held in the input register, evaluated, and presented
// from the output register. Throughput: one beat per cycle while the receiver
// does not stall; the key evaluation and the shared tick counter update are
// combinational between the input register and the output register.
// When the receiver stalls, the output beat holds and the input register
// keeps one more beat; in_ready drops only while both are full.
// Reset: all keys released, counter and long-press flags cleared, both
// channels empty, registers back to 100 and 500.
`default_nettype none
module key_short_long_press_detector #(
    parameter int unsigned KEY_COUNT = kslp_pkg::KEY_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kslp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [kslp_pkg::DATA_W-1:0]   pwdata,
    output logic      [kslp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [KEY_COUNT-1:0]          key_down_raw,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [KEY_COUNT-1:0]          short_press,
    output logic      [KEY_COUNT-1:0]          long_press,
    output logic      [KEY_COUNT-1:0]          held_keys
);

    kslp_pkg::cfg_t cfg;

    logic                       s1_valid_reg;
    logic [KEY_COUNT-1:0]       s1_raw_reg;
    logic                       s1_adv;

    logic [KEY_COUNT-1:0]       held_reg;
    logic [KEY_COUNT-1:0]       held_next;
    logic [KEY_COUNT-1:0]       rep_reg;
    logic [KEY_COUNT-1:0]       rep_next;
    logic [kslp_pkg::CNT_W-1:0] count_reg;
    logic [kslp_pkg::CNT_W-1:0] count_next;
    logic [KEY_COUNT-1:0]       shorts;
    logic [KEY_COUNT-1:0]       longs;

    logic                       out_valid_reg;
    logic [KEY_COUNT-1:0]       short_reg;
    logic [KEY_COUNT-1:0]       long_reg;
    logic [KEY_COUNT-1:0]       held_out_reg;

    kslp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kslp_key_eval #(
        .KEY_COUNT (KEY_COUNT)
    ) u_eval (
        .cfg        (cfg),
        .raw        (s1_raw_reg),
        .held       (held_reg),
        .rep        (rep_reg),
        .count      (count_reg),
        .held_next  (held_next),
        .rep_next   (rep_next),
        .count_next (count_next),
        .shorts     (shorts),
        .longs      (longs)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            rep_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_next;
                rep_reg       <= rep_next;
                count_reg     <= count_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_raw_reg <= key_down_raw;
        if (s1_adv)
        begin
            short_reg    <= shorts;
            long_reg     <= longs;
            held_out_reg <= held_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign short_press = short_reg;
    assign long_press  = long_reg;
    assign held_keys   = held_out_reg;

    // a key never reports short and long on the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((short_press & long_press) == '0))
        else $error("short and long press on the same key");

    // a short press is a release, so the key is no longer held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((short_press & held_keys) == '0))
        else $error("short press on a key still held");

    // a long press is reported only while the key is held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((long_press & ~held_keys) == '0))
        else $error("long press on a released key");

    // input side backs up only behind a stalled output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

endmodule
`default_nettype wire

@@ tb/tb_key_short_long_press_detector.sv @@
`timescale 1ns / 1ps
module tb_key_short_long_press_detector;

    localparam int unsigned KEYS = kslp_pkg::KEY_COUNT_DEF;
    localparam int unsigned CFG_ROW = 2;   // directed rows before this run at reset config
    localparam int unsigned N_DIRECTED = 22;
    localparam int unsigned N_PHASES = 6;

    typedef struct packed {
        logic [KEYS-1:0] short_press;
        logic [KEYS-1:0] long_press;
        logic [KEYS-1:0] held_keys;
    } press_beat_t;

    typedef struct packed {
        logic [KEYS-1:0] raw;
        logic            known;
        press_beat_t     beat;
    } tick_row_t;

    // rows with known = 1 carry a hand-written result, the rest use the predictor
    localparam tick_row_t DIRECTED [N_DIRECTED] = '{
        '{2'd3, 1'b1, '{2'd0, 2'd0, 2'd0}},   // reset lockout: ignored
        '{2'd0, 1'b1, '{2'd0, 2'd0, 2'd0}},
        '{2'd3, 1'b1, '{2'd0, 2'd0, 2'd3}},   // zero lockout: key 1 acts after key 0 reset
        '{2'd3, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd3, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd3, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd3, 1'b0, '{2'd0, 2'd0, 2'd0}},   // both long
        '{2'd0, 1'b0, '{2'd0, 2'd0, 2'd0}},   // release after long: no short
        '{2'd1, 1'b1, '{2'd0, 2'd0, 2'd1}},
        '{2'd0, 1'b1, '{2'd1, 2'd0, 2'd0}},
        '{2'd2, 1'b1, '{2'd0, 2'd0, 2'd2}},
        '{2'd0, 1'b1, '{2'd2, 2'd0, 2'd0}},
        '{2'd1, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd1, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd1, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd1, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd0, 1'b0, '{2'd0, 2'd0, 2'd0}},   // long tick: release not seen yet
        '{2'd0, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd2, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd3, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd1, 1'b0, '{2'd0, 2'd0, 2'd0}},
        '{2'd0, 1'b0, '{2'd0, 2'd0, 2'd0}}
    };

    localparam logic [kslp_pkg::CFG_W-1:0] PH_LOCKOUT [N_PHASES] =
        '{16'd0, 16'd1, 16'd3, 16'd0, 16'd2, 16'd6};
    localparam logic [kslp_pkg::CFG_W-1:0] PH_LONG [N_PHASES] =
        '{16'd0, 16'd4, 16'd12, 16'd65535, 16'd2, 16'd25};
    localparam int unsigned PH_TICKS [N_PHASES] = '{130, 140, 140, 90, 130, 140};

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [kslp_pkg::ADDR_W-1:0]   paddr;
    logic [kslp_pkg::DATA_W-1:0]   pwdata;
    logic [kslp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [KEYS-1:0]               key_down_raw;
    logic                          out_valid;
    logic                          out_ready;
    logic [KEYS-1:0]               short_press;
    logic [KEYS-1:0]               long_press;
    logic [KEYS-1:0]               held_keys;

    // predictor copy of config and state
    logic [kslp_pkg::CFG_W-1:0]    cfg_lockout;
    logic [kslp_pkg::CFG_W-1:0]    cfg_long;
    logic [KEYS-1:0]               keys_held;
    logic [KEYS-1:0]               long_sent;
    logic [kslp_pkg::CNT_W-1:0]    tick_count;

    press_beat_t         expected_beats [$];
    int unsigned         errors;
    bit                  tx_quiet;
    bit                  rx_quiet;
    int unsigned         rx_stall_left;

    key_short_long_press_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_down_raw (key_down_raw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .short_press  (short_press),
        .long_press   (long_press),
        .held_keys    (held_keys)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic press_beat_t advance_tick(logic [KEYS-1:0] raw);
        press_beat_t r;
        r = '0;
        if (tick_count < kslp_pkg::TICK_MAX)
            tick_count = tick_count + 1'b1;
        for (int k = 0; k < KEYS; k++)
        begin
            if (tick_count < cfg_lockout)
                continue;
            if (keys_held[k])
            begin
                if (tick_count > cfg_long && !long_sent[k])
                begin
                    r.long_press[k] = 1'b1;
                    long_sent[k] = 1'b1;
                end
                else if (!raw[k])
                begin
                    keys_held[k] = 1'b0;
                    tick_count = '0;
                    if (!long_sent[k])
                        r.short_press[k] = 1'b1;
                    long_sent[k] = 1'b0;
                end
            end
            else if (raw[k])
            begin
                keys_held[k] = 1'b1;
                tick_count = '0;
            end
        end
        r.held_keys = keys_held;
        return r;
    endfunction

    function automatic void check_field(string name, logic [KEYS-1:0] want, logic [KEYS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        press_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: short %0h long %0h held %0h",
                       short_press, long_press, held_keys);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("short_press", want.short_press, short_press);
                check_field("long_press", want.long_press, long_press);
                check_field("held_keys", want.held_keys, held_keys);
            end
        end
    end

    // receiver stalls at random, in bursts
    always @(negedge clk)
    begin
        if (rx_quiet)
            out_ready <= 1'b1;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rx_stall_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_tick(logic [KEYS-1:0] raw, logic known, press_beat_t typed);
        int unsigned pause;
        press_beat_t predicted;
        @(negedge clk);
        if (!tx_quiet && $urandom_range(0, 7) == 0)
        begin
            pause = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        in_valid <= 1'b1;
        key_down_raw <= raw;
        do @(posedge clk); while (!in_ready);
        predicted = advance_tick(raw);
        expected_beats.push_back(known ? typed : predicted);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_access(bit wr, kslp_pkg::reg_idx_t idx,
                              logic [kslp_pkg::CFG_W-1:0] value);
        logic [kslp_pkg::CFG_W-1:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= kslp_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= wr ? kslp_pkg::DATA_W'(value) : '0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (wr)
        begin
            if (idx == kslp_pkg::REG_LOCKOUT)
                cfg_lockout = value;
            else
                cfg_long = value;
        end
        else
        begin
            want = (idx == kslp_pkg::REG_LOCKOUT) ? cfg_lockout : cfg_long;
            if (prdata !== kslp_pkg::DATA_W'(want))
            begin
                $error("prdata: expected %0h, got %0h", kslp_pkg::DATA_W'(want), prdata);
                errors++;
            end
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [kslp_pkg::CFG_W-1:0] lockout,
                              logic [kslp_pkg::CFG_W-1:0] long_ms);
        wait_drained();
        reg_access(1'b1, kslp_pkg::REG_LOCKOUT, lockout);
        reg_access(1'b1, kslp_pkg::REG_LONG_PRESS, long_ms);
        reg_access(1'b0, kslp_pkg::REG_LOCKOUT, '0);
        reg_access(1'b0, kslp_pkg::REG_LONG_PRESS, '0);
    endtask

    // mostly press / hold / release sequences with bounce, some pure noise
    task automatic press_traffic(int unsigned n_ticks);
        int unsigned sent;
        int unsigned drain_at;
        int unsigned gap;
        int unsigned hold;
        int unsigned cap;
        int unsigned burst;
        bit drained;
        logic [KEYS-1:0] mask;
        logic [KEYS-1:0] raw;
        sent = 0;
        drained = 1'b0;
        drain_at = $urandom_range(n_ticks / 4, 3 * n_ticks / 4);
        while (sent < n_ticks)
        begin
            if (!drained && sent >= drain_at)
            begin
                wait_drained();
                drained = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                begin
                    send_tick(KEYS'($urandom), 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                gap = $urandom_range(0, (cfg_lockout < 20 ? cfg_lockout : 20) + 2);
                repeat (gap)
                begin
                    raw = '0;
                    if ($urandom_range(0, 9) == 0)
                        raw[$urandom_range(0, KEYS - 1)] = 1'b1;
                    send_tick(raw, 1'b0, '0);
                    sent++;
                end
                mask = KEYS'($urandom_range(1, (1 << KEYS) - 1));
                cap = (cfg_long < 40) ? cfg_long + 1 : 40;
                hold = $urandom_range(0, 1) ? $urandom_range(1, cap) : cap + $urandom_range(1, 4);
                repeat (hold)
                begin
                    raw = mask;
                    if ($urandom_range(0, 9) == 0)
                        raw[$urandom_range(0, KEYS - 1)] ^= 1'b1;
                    send_tick(raw, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        key_down_raw = '0;
        out_ready = 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        rx_stall_left = 0;
        cfg_lockout = kslp_pkg::LOCKOUT_RESET;
        cfg_long = kslp_pkg::LONG_PRESS_RESET;
        keys_held = '0;
        long_sent = '0;
        tick_count = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers come up at their reset values
        reg_access(1'b0, kslp_pkg::REG_LOCKOUT, '0);
        reg_access(1'b0, kslp_pkg::REG_LONG_PRESS, '0);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (i == CFG_ROW)
                set_config(16'd0, 16'd3);
            send_tick(DIRECTED[i].raw, DIRECTED[i].known, DIRECTED[i].beat);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_config(PH_LOCKOUT[p], PH_LONG[p]);
            press_traffic(PH_TICKS[p]);
        end

        set_config(16'd4, 16'd10);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        press_traffic(150);

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/kslp_pkg.sv
rtl/kslp_cfg_regs.sv
rtl/kslp_key_eval.sv
rtl/key_short_long_press_detector.sv
tb/tb_key_short_long_press_detector.sv
